@@ design/kvt_pkg.sv @@
// Shared types and constants for the key/value line tokenizer.
// Used by every module of the block; depends on nothing else.
package kvt_pkg;

   localparam int LINE_LIMIT = 256;
   localparam int CNT_W = $clog2(LINE_LIMIT + 1);
   localparam int LEN_W = 9;
   localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(256);

   typedef enum logic [2:0] {
      KIND_KEY_BYTE = 3'd0,
      KIND_KEY_END  = 3'd1,
      KIND_VAL_BYTE = 3'd2,
      KIND_OK       = 3'd3,
      KIND_ERR      = 3'd4,
      KIND_EOD      = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      PH_SKIP    = 3'd0,
      PH_COMMENT = 3'd1,
      PH_KEY     = 3'd2,
      PH_VALWS   = 3'd3,
      PH_VAL     = 3'd4
   } phase_type;

   localparam logic [0:0] REG_MAX_LEN = 1'b0;

   // One queued work entry: the one or two results that a single byte causes.
   typedef struct packed {
      logic     two;
      kind_type kind0;
      logic [7:0] char0;
      kind_type kind1;
      logic [7:0] char1;
   } entry_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

@@ design/kvt_front.sv @@
// Front end of the tokenizer: accepts bytes, runs the parse state and
// turns each byte into zero, one or two queued results. Uses kvt_pkg.
module kvt_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [kvt_pkg::LEN_W-1:0]   max_len,
   input  logic                        accept,
   input  logic                        cmd,
   input  logic [7:0]                  char_in,
   output logic                        push,
   output kvt_pkg::entry_type          push_data
);

   kvt_pkg::phase_type          phase_ff, phase_in;
   logic                        held_valid_ff, held_valid_in;
   logic [7:0]                  held_byte_ff, held_byte_in;
   logic [kvt_pkg::CNT_W-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= kvt_pkg::PH_SKIP;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         count_ff      <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         count_ff      <= count_in;
      end
   end

   always_comb begin
      logic [1:0]                 n;
      kvt_pkg::kind_type          rk [2];
      logic [7:0]                 rc [2];
      logic                       do_key;
      logic                       do_val;
      logic [kvt_pkg::CMP_W-1:0]  limit;
      logic [kvt_pkg::CMP_W-1:0]  next_cnt;
      logic                       too_long;

      n      = 2'd0;
      rk[0]  = kvt_pkg::KIND_KEY_BYTE;
      rk[1]  = kvt_pkg::KIND_KEY_BYTE;
      rc[0]  = '0;
      rc[1]  = '0;
      do_key = 1'b0;
      do_val = 1'b0;
      phase_in      = phase_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      count_in      = count_ff;

      if (kvt_pkg::CMP_W'(max_len) > kvt_pkg::CMP_W'(kvt_pkg::LINE_LIMIT)) begin
         limit = kvt_pkg::CMP_W'(kvt_pkg::LINE_LIMIT);
      end else begin
         limit = kvt_pkg::CMP_W'(max_len);
      end
      next_cnt = kvt_pkg::CMP_W'(count_ff) + kvt_pkg::CMP_W'(1);
      too_long = next_cnt > limit;

      if (cmd) begin
         phase_in      = kvt_pkg::PH_SKIP;
         held_valid_in = 1'b0;
         held_byte_in  = '0;
         count_in      = '0;
         rk[0] = kvt_pkg::KIND_EOD;
         n     = 2'd1;
      end else begin
         unique case (phase_ff)
            kvt_pkg::PH_SKIP: begin
               if (kvt_pkg::is_ws(char_in)) begin
                  phase_in = kvt_pkg::PH_SKIP;
               end else if (char_in == kvt_pkg::CHAR_HASH) begin
                  phase_in = kvt_pkg::PH_COMMENT;
               end else begin
                  do_key = 1'b1;
               end
            end
            kvt_pkg::PH_COMMENT: begin
               if (char_in == kvt_pkg::CHAR_NEWLINE) begin
                  phase_in = kvt_pkg::PH_SKIP;
               end
            end
            kvt_pkg::PH_KEY: begin
               do_key = 1'b1;
            end
            kvt_pkg::PH_VALWS: begin
               if (char_in == kvt_pkg::CHAR_NEWLINE) begin
                  rk[0] = kvt_pkg::KIND_OK;
                  n     = 2'd1;
                  phase_in      = kvt_pkg::PH_SKIP;
                  held_valid_in = 1'b0;
                  held_byte_in  = '0;
                  count_in      = '0;
               end else if (!kvt_pkg::is_ws(char_in)) begin
                  do_val = 1'b1;
               end
            end
            kvt_pkg::PH_VAL: begin
               do_val = 1'b1;
            end
            default: begin
               phase_in      = kvt_pkg::PH_SKIP;
               held_valid_in = 1'b0;
               held_byte_in  = '0;
               count_in      = '0;
            end
         endcase

         // A record that starts in the skip phase has a clear held byte and count.
         if (do_key && (phase_ff == kvt_pkg::PH_SKIP)) begin
            held_valid_in = 1'b0;
            held_byte_in  = '0;
         end

         if (do_key) begin
            if (char_in == kvt_pkg::CHAR_NEWLINE) begin
               rk[0] = kvt_pkg::KIND_ERR;
               n     = 2'd1;
               phase_in      = kvt_pkg::PH_SKIP;
               held_valid_in = 1'b0;
               held_byte_in  = '0;
               count_in      = '0;
            end else if (char_in == kvt_pkg::CHAR_COLON) begin
               if (held_valid_in && (held_byte_in == kvt_pkg::CHAR_BACKSLASH)) begin
                  // Escaped colon replaces the held backslash.
                  held_byte_in = kvt_pkg::CHAR_COLON;
                  phase_in     = kvt_pkg::PH_KEY;
               end else begin
                  if (held_valid_in) begin
                     rk[n[0]] = kvt_pkg::KIND_KEY_BYTE;
                     rc[n[0]] = held_byte_in;
                     n        = n + 2'd1;
                  end
                  rk[n[0]] = kvt_pkg::KIND_KEY_END;
                  rc[n[0]] = '0;
                  n        = n + 2'd1;
                  phase_in      = kvt_pkg::PH_VALWS;
                  held_valid_in = 1'b0;
                  held_byte_in  = '0;
                  count_in      = '0;
               end
            end else if (too_long) begin
               rk[0] = kvt_pkg::KIND_ERR;
               n     = 2'd1;
               phase_in      = kvt_pkg::PH_SKIP;
               held_valid_in = 1'b0;
               held_byte_in  = '0;
               count_in      = '0;
            end else begin
               if (held_valid_in) begin
                  rk[0] = kvt_pkg::KIND_KEY_BYTE;
                  rc[0] = held_byte_in;
                  n     = 2'd1;
               end
               phase_in      = kvt_pkg::PH_KEY;
               held_byte_in  = char_in;
               held_valid_in = 1'b1;
               count_in      = next_cnt[kvt_pkg::CNT_W-1:0];
            end
         end

         if (do_val) begin
            if (char_in == kvt_pkg::CHAR_NEWLINE) begin
               rk[0] = kvt_pkg::KIND_OK;
               n     = 2'd1;
               phase_in      = kvt_pkg::PH_SKIP;
               held_valid_in = 1'b0;
               held_byte_in  = '0;
               count_in      = '0;
            end else if (too_long) begin
               rk[0] = kvt_pkg::KIND_ERR;
               n     = 2'd1;
               phase_in      = kvt_pkg::PH_SKIP;
               held_valid_in = 1'b0;
               held_byte_in  = '0;
               count_in      = '0;
            end else begin
               rk[0] = kvt_pkg::KIND_VAL_BYTE;
               rc[0] = char_in;
               n     = 2'd1;
               phase_in = kvt_pkg::PH_VAL;
               count_in = next_cnt[kvt_pkg::CNT_W-1:0];
            end
         end
      end

      push            = accept && (n != 2'd0);
      push_data.two   = n[1];
      push_data.kind0 = rk[0];
      push_data.char0 = rc[0];
      push_data.kind1 = rk[1];
      push_data.char1 = rc[1];
   end

endmodule

@@ design/kvt_queue.sv @@
// Short queue of work entries between the front and back ends.
// Uses kvt_pkg for the entry type and depth.
module kvt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kvt_pkg::entry_type  push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output kvt_pkg::entry_type  head
);

   kvt_pkg::entry_type          slot_ff [kvt_pkg::QUEUE_DEPTH];
   logic [kvt_pkg::PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [kvt_pkg::PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [kvt_pkg::FILL_W-1:0]  fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + kvt_pkg::PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + kvt_pkg::PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + kvt_pkg::FILL_W'(push) - kvt_pkg::FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = (fill_ff == kvt_pkg::FILL_W'(kvt_pkg::QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

endmodule

@@ design/kvt_back.sv @@
// Back end of the tokenizer: unpacks queued entries into single results
// and holds them in the output register. Uses kvt_pkg.
module kvt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  kvt_pkg::entry_type  head,
   output logic                pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output kvt_pkg::kind_type   rsp_kind,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_last
);

   logic               valid_ff, valid_in;
   logic               sub_ff, sub_in;
   kvt_pkg::kind_type  kind_ff, kind_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;
   logic               load;

   always_comb begin
      load     = !valid_ff || !rsp_stall;
      valid_in = valid_ff;
      sub_in   = sub_ff;
      kind_in  = kind_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            kind_in = sub_ff ? head.kind1 : head.kind0;
            char_in = sub_ff ? head.char1 : head.char0;
            last_in = sub_ff || !head.two;
            pop     = last_in;
            sub_in  = !last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last     = last_ff;

endmodule

@@ design/key_value_line_tokenizer_core.sv @@
// Results of an accepted byte go through the queue, then the output register.
// Throughput: one byte and one output result per cycle while neither side stalls,
// so bytes that cause two results (key byte plus key end) take two output transfers.
// A four-entry queue between front and back absorbs those bursts and output stalls.
// Reset (synchronous, active high) returns parsing to leading-whitespace skip,
// empties the queue and output, and sets max_field_length to 256.
module key_value_line_tokenizer_core (
   input  logic         clock,
   input  logic         reset,
   // Input byte channel.
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_cmd,
   input  logic [7:0]   req_char_in,
   // Result channel.
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_kind,
   output logic [7:0]   rsp_char_out,
   output logic         rsp_last,
   // Register port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // The single register, max_field_length, sits at byte address 0. Address bit 2
   // selects the register index; anything other than index zero reads as zero
   // and ignores writes.
   logic [kvt_pkg::LEN_W-1:0]  max_len_ff;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= kvt_pkg::MAX_LEN_RESET;
      end else if (csr_write && (csr_paddr[2] == kvt_pkg::REG_MAX_LEN)) begin
         max_len_ff <= csr_pwdata[kvt_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == kvt_pkg::REG_MAX_LEN) begin
         csr_prdata = 32'(max_len_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // The front end accepts a byte whenever the queue has room. Each accepted
   // transfer is classified in the same cycle and its results are queued as
   // one entry; bytes that cause no result (whitespace, comments, a held key
   // byte) only update the parse state.
   logic                queue_full;
   logic                queue_empty;
   logic                accept;
   logic                push;
   logic                pop;
   kvt_pkg::entry_type  push_data;
   kvt_pkg::entry_type  head;
   kvt_pkg::kind_type   out_kind;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   kvt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .max_len   (max_len_ff),
      .accept    (accept),
      .cmd       (req_cmd),
      .char_in   (req_char_in),
      .push      (push),
      .push_data (push_data)
   );

   kvt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   // The back end loads the output register whenever it is empty or its
   // current transfer completes, so a result can leave on every cycle.
   kvt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (queue_empty),
      .head         (head),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (out_kind),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   assign rsp_kind = out_kind;

endmodule

@@ design/kvt_checker.sv @@
// Port-level checks for the tokenizer core, attached by bind.
// Depends on kvt_pkg and key_value_line_tokenizer_core.
module kvt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_char_out,
   input  logic        rsp_last
);

   // A stalled result transfer keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_char_out) && $stable(rsp_last))
      else $error("stalled result changed");

   // Only key and value bytes carry a character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != kvt_pkg::KIND_KEY_BYTE)
         && (rsp_kind != kvt_pkg::KIND_VAL_BYTE) |-> (rsp_char_out == 8'd0))
      else $error("non-byte result carries a character");

   // End of data, record ok and record error always close a byte's results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == kvt_pkg::KIND_EOD) || (rsp_kind == kvt_pkg::KIND_OK)
         || (rsp_kind == kvt_pkg::KIND_ERR)) |-> rsp_last)
      else $error("closing result not marked last");

   // A key byte is never the last result when followed by a key end in the same entry,
   // so a non-last result is always a key byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_kind == kvt_pkg::KIND_KEY_BYTE))
      else $error("unexpected non-last result");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind key_value_line_tokenizer_core kvt_checker u_kvt_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_kind     (rsp_kind),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);
